@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define MWSC_ASSERT_NOW(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication, checked out of reset
`define MWSC_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

@@ rtl/core/mwsc_pkg.sv @@
package mwsc_pkg;

   localparam int WidthBits = 13;

   localparam logic signed [14:0] FixedStep = 15'sd5;
   localparam logic signed [14:0] FixedSpan = 15'sd30;
   localparam logic signed [14:0] WidthMax  = 15'sd4095;

   // register indexes on the csr channel
   localparam logic [2:0] CSR_FIXED_ENABLE   = 3'd0;
   localparam logic [2:0] CSR_FIXED_WIDTH    = 3'd1;
   localparam logic [2:0] CSR_UNIDIRECTIONAL = 3'd2;
   localparam logic [2:0] CSR_SWITCH_FLEX    = 3'd3;
   localparam logic [2:0] CSR_START_PINS     = 3'd4;
   localparam logic [2:0] CSR_VERIFY_ENABLE  = 3'd5;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SEARCH,
      PH_VERIFY
   } phase_type;

   typedef enum logic [2:0] {
      ST_TRY,
      ST_DONE,
      ST_ODD_WIDTH,
      ST_FS_NOT_MULT3,
      ST_LIMIT,
      ST_OVERRUN
   } status_type;

   typedef struct packed {
      logic       fixed_enable;
      logic [9:0] fixed_width;
      logic       unidirectional;
      logic [5:0] switch_flex;
      logic [9:0] start_pins;
      logic       verify_enable;
   } cfg_type;

   typedef struct packed {
      phase_type                     phase;
      logic signed [WidthBits-1:0] low_bound;
      logic signed [WidthBits-1:0] high_bound;
      logic signed [WidthBits-1:0] current_width;
      logic signed [WidthBits-1:0] best_width;
      logic                          prev_ok;
      logic                          prev2_ok;
   } state_type;

   typedef struct packed {
      logic [11:0]                   try_width;
      status_type                    status;
      logic signed [WidthBits-1:0] final_width;
   } result_type;

   // divisibility by 3: sum of base-4 digits keeps the residue mod 3
   function automatic logic is_mult3(input logic [5:0] v);
      logic [3:0] s;
      s = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]};
      return (s == 4'd0) || (s == 4'd3) || (s == 4'd6) || (s == 4'd9);
   endfunction

endpackage

@@ rtl/core/mwsc_step.sv @@
module mwsc_step #(
   parameter int WIDTH_LIMIT = 1000
) (
   input  mwsc_pkg::cfg_type    cfg,
   input  mwsc_pkg::state_type  state_cur,
   input  logic                 mode,
   input  logic                 routed_ok,
   input  logic                 conn_clipped,
   output mwsc_pkg::state_type  state_nxt,
   output logic                 emit,
   output mwsc_pkg::result_type result
);

   localparam logic signed [14:0] LimitS = 15'(WIDTH_LIMIT);

   logic signed [14:0] cw, lo, hi, best, m, fw, fs, step5;
   logic               done, do_search_top, do_start_verify, do_verify_top, good;
   logic               p_ok, p2_ok;
   mwsc_pkg::status_type code;
   mwsc_pkg::phase_type  ph;

   always_comb begin
      cw    = {{2{state_cur.current_width[12]}}, state_cur.current_width};
      lo    = {{2{state_cur.low_bound[12]}}, state_cur.low_bound};
      hi    = {{2{state_cur.high_bound[12]}}, state_cur.high_bound};
      best  = {{2{state_cur.best_width[12]}}, state_cur.best_width};
      p_ok  = state_cur.prev_ok;
      p2_ok = state_cur.prev2_ok;
      ph    = state_cur.phase;
      m     = cfg.unidirectional ? 15'sd2 : 15'sd1;
      step5 = cfg.unidirectional ? (mwsc_pkg::FixedStep <<< 1) : mwsc_pkg::FixedStep;
      fw    = $signed({5'd0, cfg.fixed_width});
      fs    = $signed({9'd0, cfg.switch_flex});
      good  = routed_ok && !conn_clipped;
      done            = 1'b0;
      do_search_top   = 1'b0;
      do_start_verify = 1'b0;
      do_verify_top   = 1'b0;
      emit            = 1'b0;
      code            = mwsc_pkg::ST_TRY;

      if (!mode) begin
         emit = 1'b1;
         ph   = mwsc_pkg::PH_SEARCH;
         best = -15'sd1;
         hi   = -15'sd1;
         if (cfg.fixed_enable) begin
            cw = fw + step5;
            lo = fw - m;
         end else begin
            cw = $signed({5'd0, cfg.start_pins}) + $signed({14'd0, cfg.start_pins[0]});
            lo = -15'sd1;
         end
         if (cfg.unidirectional && cw[0]) begin
            done = 1'b1;
            code = mwsc_pkg::ST_ODD_WIDTH;
         end else if (!cfg.unidirectional && !mwsc_pkg::is_mult3(cfg.switch_flex)) begin
            done = 1'b1;
            code = mwsc_pkg::ST_FS_NOT_MULT3;
         end else begin
            do_search_top = 1'b1;
         end
      end else if (state_cur.phase == mwsc_pkg::PH_SEARCH) begin
         emit = 1'b1;
         if (good) begin
            if (cw == hi) best = cw;
            hi = cw;
            if (hi - lo <= m) best = hi;
            if (lo != -15'sd1) cw = (hi + lo) >>> 1;
            else cw = hi >>> 1;
         end else begin
            lo = cw;
            if (hi != -15'sd1) begin
               if (hi - lo <= m) best = hi;
               cw = (hi + lo) >>> 1;
            end else if (cfg.fixed_enable) begin
               if (lo < fw + mwsc_pkg::FixedSpan) begin
                  cw = lo + step5;
               end else begin
                  done = 1'b1;
                  code = mwsc_pkg::ST_OVERRUN;
               end
            end else begin
               cw = lo <<< 1;
            end
         end
         if (!done) begin
            // clamp negative widths to zero, round up to even when unidirectional, cap at WidthMax
            if (cw < 15'sd0) cw = 15'sd0;
            if (cfg.unidirectional) cw = cw + $signed({14'd0, cw[0]});
            if (cw > mwsc_pkg::WidthMax) cw = mwsc_pkg::WidthMax;
            if (best != -15'sd1) do_start_verify = 1'b1;
            else do_search_top = 1'b1;
         end
      end else if (state_cur.phase == mwsc_pkg::PH_VERIFY) begin
         emit = 1'b1;
         if (good) best = cw;
         p2_ok = p_ok;
         p_ok  = routed_ok;
         cw    = cw - m;
         do_verify_top = 1'b1;
      end

      if (do_search_top) begin
         if (cfg.fixed_enable ? (cw > (fw <<< 2)) : (cw > LimitS)) begin
            done = 1'b1;
            code = mwsc_pkg::ST_LIMIT;
         end else if (cw + (cw <<< 1) < fs) begin
            best = hi;
            do_start_verify = 1'b1;
         end
      end

      if (do_start_verify) begin
         if (!cfg.verify_enable) begin
            done = 1'b1;
            code = mwsc_pkg::ST_DONE;
         end else begin
            ph    = mwsc_pkg::PH_VERIFY;
            p_ok  = 1'b1;
            p2_ok = 1'b1;
            cw    = best - 15'sd2;
            do_verify_top = 1'b1;
         end
      end

      if (do_verify_top) begin
         if ((!p_ok && !p2_ok) || (cfg.fixed_enable && cw < fw) || cw < 15'sd1) begin
            done = 1'b1;
            code = mwsc_pkg::ST_DONE;
         end
      end

      if (done) ph = mwsc_pkg::PH_IDLE;

      state_nxt.phase         = ph;
      state_nxt.low_bound     = lo[12:0];
      state_nxt.high_bound    = hi[12:0];
      state_nxt.current_width = cw[12:0];
      state_nxt.best_width    = best[12:0];
      state_nxt.prev_ok       = p_ok;
      state_nxt.prev2_ok      = p2_ok;

      result.try_width   = done ? 12'd0 : cw[11:0];
      result.status      = code;
      result.final_width = best[12:0];
   end

endmodule

@@ rtl/core/min_width_search_controller_unit.sv @@
// Minimum channel width search controller.
// req channel: one item per routing attempt. tuser[0] is mode (0 starts a new
//   search from the csr settings, 1 reports the last attempt), tdata carries
//   routed_ok and conn_clipped. A report while no search runs is dropped.
// rsp channel: one item per start or report: try_width, status and the best
//   width so far (final_width, -1 if none). Status other than "try next"
//   ends the search.
// csr channel: always ready; write only while no item is in flight.
// Path: an accepted item is held in the input register, and its result is
//   written to the output register once that register is free or being read.
// Throughput: one item per cycle while rsp results are taken; the search state update
//   is a single compare/add/halve pass between the input and output registers.
// Stall: while a result waits on rsp_tready the input register keeps one more
//   item, then req_tready drops until the result is taken.
// Reset: synchronous, clears both handshake stages, sets the csr fields to
//   their defaults and puts the search in idle with no best width.
`include "assert_macros.svh"

module min_width_search_controller_unit #(
   parameter int WIDTH_LIMIT = 1000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] routed_ok, [1] conn_clipped, rest zero
   input  logic [0:0]  req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [11:0] try_width, [24:12] final_width, rest zero
   output logic [2:0]  rsp_tuser,   // [2:0] status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_wdata
);

   mwsc_pkg::cfg_type    cfg_ff;
   mwsc_pkg::state_type  state_ff, state_in;
   mwsc_pkg::result_type out_ff, result_in;
   logic                 in_v_ff, out_v_ff;
   logic                 in_mode_ff, in_routed_ff, in_clipped_ff;
   logic                 advance, emit;

   assign advance    = in_v_ff && (!out_v_ff || rsp_tready);
   assign req_tready = !in_v_ff || advance;
   assign csr_ready  = 1'b1;

   mwsc_step #(
      .WIDTH_LIMIT(WIDTH_LIMIT)
   ) u_step (
      .cfg          (cfg_ff),
      .state_cur    (state_ff),
      .mode         (in_mode_ff),
      .routed_ok    (in_routed_ff),
      .conn_clipped (in_clipped_ff),
      .state_nxt    (state_in),
      .emit         (emit),
      .result       (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fixed_enable   <= 1'b0;
         cfg_ff.fixed_width    <= 10'd1;
         cfg_ff.unidirectional <= 1'b0;
         cfg_ff.switch_flex    <= 6'd3;
         cfg_ff.start_pins     <= 10'd0;
         cfg_ff.verify_enable  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            mwsc_pkg::CSR_FIXED_ENABLE:   cfg_ff.fixed_enable   <= csr_wdata[0];
            mwsc_pkg::CSR_FIXED_WIDTH:    cfg_ff.fixed_width    <= csr_wdata;
            mwsc_pkg::CSR_UNIDIRECTIONAL: cfg_ff.unidirectional <= csr_wdata[0];
            mwsc_pkg::CSR_SWITCH_FLEX:    cfg_ff.switch_flex    <= csr_wdata[5:0];
            mwsc_pkg::CSR_START_PINS:     cfg_ff.start_pins     <= csr_wdata;
            mwsc_pkg::CSR_VERIFY_ENABLE:  cfg_ff.verify_enable  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff                 <= 1'b0;
         out_v_ff                <= 1'b0;
         state_ff.phase          <= mwsc_pkg::PH_IDLE;
         state_ff.low_bound      <= -13'sd1;
         state_ff.high_bound     <= -13'sd1;
         state_ff.current_width  <= 13'sd0;
         state_ff.best_width     <= -13'sd1;
         state_ff.prev_ok        <= 1'b1;
         state_ff.prev2_ok       <= 1'b1;
      end else begin
         if (req_tready) in_v_ff <= req_tvalid;
         if (advance) begin
            out_v_ff <= emit;
            state_ff <= state_in;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_mode_ff    <= req_tuser[0];
         in_routed_ff  <= req_tdata[0];
         in_clipped_ff <= req_tdata[1];
      end
      if (advance && emit) out_ff <= result_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {7'd0, out_ff.final_width, out_ff.try_width};
   assign rsp_tuser  = out_ff.status;

   // a result that ends the search leaves the controller idle
   `MWSC_ASSERT_NEXT(a_end_idle, clock, reset,
      advance && emit && result_in.status != mwsc_pkg::ST_TRY,
      state_ff.phase == mwsc_pkg::PH_IDLE)
   // a stalled output holds back the search state
   `MWSC_ASSERT_NEXT(a_stall_holds, clock, reset,
      in_v_ff && out_v_ff && !rsp_tready, $stable(state_ff))
   // an odd-width abort only happens with unidirectional wiring
   `MWSC_ASSERT_NOW(a_odd_unidir, clock, reset,
      out_v_ff && out_ff.status == mwsc_pkg::ST_ODD_WIDTH, cfg_ff.unidirectional)

endmodule
